>>> hw/rtl/bec_pkg.sv
package bec_pkg;

   localparam int NUM_BUTTONS = 5;
   localparam int TIME_BITS   = 32;
   localparam int INTERVAL_BITS = 32;

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(300);

   typedef enum logic [1:0] {
      PHASE_NONE     = 2'd0,
      PHASE_PRESSED  = 2'd1,
      PHASE_RELEASED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] button_levels;
      logic [TIME_BITS-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] held_mask;
      logic [NUM_BUTTONS-1:0] pressed_mask;
      logic [NUM_BUTTONS-1:0] released_mask;
      logic [NUM_BUTTONS-1:0] single_click_mask;
      logic [NUM_BUTTONS-1:0] double_click_mask;
   } rsp_type;

   typedef struct packed {
      logic held;
      logic pressed;
      logic released;
      logic single_click;
      logic double_click;
   } lane_flags_type;

endpackage

>>> hw/rtl/bec_lane.sv
module bec_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    update,
   input  logic                                    level,
   input  logic [bec_pkg::TIME_BITS-1:0]           now_ms,
   input  logic [bec_pkg::INTERVAL_BITS-1:0]       interval,
   output bec_pkg::lane_flags_type                 flags
);

   logic                          last_level_ff;
   bec_pkg::phase_type            phase_ff;
   bec_pkg::phase_type            phase_in;
   logic [bec_pkg::TIME_BITS-1:0] stamp_ff;
   logic [bec_pkg::TIME_BITS-1:0] stamp_in;
   logic [bec_pkg::TIME_BITS-1:0] gap;
   logic                          in_window;
   logic                          press_edge;
   logic                          release_edge;

   assign gap          = now_ms - stamp_ff;
   assign in_window    = gap <= bec_pkg::TIME_BITS'(interval);
   assign press_edge   = level && !last_level_ff;
   assign release_edge = !level && last_level_ff;

   always_comb begin
      phase_in           = phase_ff;
      stamp_in           = stamp_ff;
      flags              = '0;
      flags.held         = level;
      flags.pressed      = press_edge;
      flags.released     = release_edge;
      if (press_edge) begin
         if (phase_ff == bec_pkg::PHASE_RELEASED) begin
            phase_in = bec_pkg::PHASE_NONE;
            if (in_window) begin
               flags.double_click = 1'b1;
            end else begin
               stamp_in = '0;
            end
         end else begin
            phase_in = bec_pkg::PHASE_PRESSED;
            stamp_in = now_ms;
         end
      end else if (release_edge) begin
         if (in_window) begin
            flags.single_click = 1'b1;
            phase_in           = bec_pkg::PHASE_RELEASED;
            stamp_in           = now_ms;
         end else begin
            phase_in = bec_pkg::PHASE_NONE;
            stamp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         phase_ff      <= bec_pkg::PHASE_NONE;
         stamp_ff      <= '0;
      end else if (update) begin
         last_level_ff <= level;
         phase_ff      <= phase_in;
         stamp_ff      <= stamp_in;
      end
   end

endmodule

>>> hw/rtl/bec_merge.sv
module bec_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  bec_pkg::lane_flags_type [bec_pkg::NUM_BUTTONS-1:0] lane_flags,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output bec_pkg::rsp_type                              rsp_data
);

   bec_pkg::rsp_type rsp_data_in;
   bec_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff;

   always_comb begin
      for (int b = 0; b < bec_pkg::NUM_BUTTONS; b++) begin
         rsp_data_in.held_mask[b]         = lane_flags[b].held;
         rsp_data_in.pressed_mask[b]      = lane_flags[b].pressed;
         rsp_data_in.released_mask[b]     = lane_flags[b].released;
         rsp_data_in.single_click_mask[b] = lane_flags[b].single_click;
         rsp_data_in.double_click_mask[b] = lane_flags[b].double_click;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/button_edge_and_click_detector_unit.sv
// Result: registered, valid in the cycle after the request transaction.
// Throughput: one transaction per cycle unless the response side stalls;
// one lane per button (subtract, compare to click interval), one merge register.
// Reset: synchronous; levels, phases and stamps clear to zero, interval to 300.
// Request ready drops only while a result waits and the response side stalls.
module button_edge_and_click_detector_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bec_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bec_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bec_pkg::INTERVAL_BITS-1:0]    csr_data
);

   logic [bec_pkg::INTERVAL_BITS-1:0]                  interval_ff;
   logic                                               accept;
   bec_pkg::lane_flags_type [bec_pkg::NUM_BUTTONS-1:0] lane_flags;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= bec_pkg::INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_data;
      end
   end

   for (genvar b = 0; b < bec_pkg::NUM_BUTTONS; b++) begin : g_lane
      bec_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .update   (accept),
         .level    (req_data.button_levels[b]),
         .now_ms   (req_data.now_ms),
         .interval (interval_ff),
         .flags    (lane_flags[b])
      );
   end

   bec_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .lane_flags (lane_flags),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
